// File: rtl/mfr_pkg.sv
// shared types, constants and crc helpers of the ms/tp frame receiver
package mfr_pkg;

	localparam int COUNTER_WIDTH_DEF = 32;
	localparam int CNT_OUT_W         = 32;
	localparam int HDR_BYTES         = 5;

	localparam logic [7:0]  SYNC_BYTE     = 8'h55;
	localparam logic [7:0]  FLAG_BYTE     = 8'hFF;
	localparam logic [7:0]  CRC8_POLY     = 8'h81;
	localparam logic [7:0]  CRC8_INIT     = 8'hFF;
	localparam logic [15:0] CRC16_POLY    = 16'h8408;
	localparam logic [15:0] CRC16_INIT    = 16'hFFFF;
	localparam logic [15:0] MAX_LEN_RESET = 16'd2000;

	typedef logic [2:0] evt_code_t;

	localparam evt_code_t EV_NONE        = 3'd0;
	localparam evt_code_t EV_HDR_NODATA  = 3'd1;
	localparam evt_code_t EV_HDR_CRCERR  = 3'd2;
	localparam evt_code_t EV_HDR_DATA    = 3'd3;
	localparam evt_code_t EV_DATA        = 3'd4;
	localparam evt_code_t EV_FRAME_OK    = 3'd5;
	localparam evt_code_t EV_DATA_CRCERR = 3'd6;

	// one received byte with its preamble class
	typedef struct packed {
		logic [7:0] data;
		logic       is_sync;
		logic       is_flag;
	} rx_item_t;

	// handshake between front queue and back end
	typedef struct packed {
		logic     valid;
		rx_item_t item;
	} q_head_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/mfr_front.sv
// front end: byte acceptance, preamble classification and two-entry queue
module mfr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte_in,
	output mfr_pkg::q_head_t head,
	input  logic             pop
);

	mfr_pkg::rx_item_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              do_pop;
	mfr_pkg::rx_item_t cls;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (count_q != 2'd0);

	always_comb begin
		cls.data    = rx_byte_in;
		cls.is_sync = (rx_byte_in == mfr_pkg::SYNC_BYTE);
		cls.is_flag = (rx_byte_in == mfr_pkg::FLAG_BYTE);
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/mfr_back.sv
// back end: frame state machine, crc checks, counters and result register
module mfr_back #(
	parameter int COUNTER_WIDTH = mfr_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mfr_pkg::q_head_t             head,
	output logic                         pop,
	input  logic                         cfg_valid,
	input  logic [15:0]                  cfg_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mfr_pkg::evt_code_t           event_code,
	output logic [7:0]                   data_byte_out,
	output logic [7:0]                   frame_kind,
	output logic [7:0]                   dest_station,
	output logic [7:0]                   src_station,
	output logic [15:0]                  frame_data_length,
	output logic [mfr_pkg::CNT_OUT_W-1:0] count_frames,
	output logic [mfr_pkg::CNT_OUT_W-1:0] count_tokens,
	output logic [mfr_pkg::CNT_OUT_W-1:0] count_data_frames,
	output logic [mfr_pkg::CNT_OUT_W-1:0] count_header_errors,
	output logic [mfr_pkg::CNT_OUT_W-1:0] count_data_errors
);

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_PREAMBLE = 3'd1;
	localparam logic [2:0] PH_HEADER   = 3'd2;
	localparam logic [2:0] PH_DATA     = 3'd3;
	localparam logic [2:0] PH_CRC16    = 3'd4;

	localparam int CNT_FRAMES   = 0;
	localparam int CNT_TOKENS   = 1;
	localparam int CNT_DATA     = 2;
	localparam int CNT_HDR_ERR  = 3;
	localparam int CNT_DATA_ERR = 4;

	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

	logic [15:0]              max_len_q;
	logic [2:0]               phase_q, phase_n;
	logic [2:0]               hcount_q, hcount_n;
	logic [7:0]               hcrc_q, hcrc_n;
	logic [7:0]               hfield_q [mfr_pkg::HDR_BYTES];
	logic                     hfield_we;
	logic [15:0]              dcount_q, dcount_n;
	logic [15:0]              dcrc_q, dcrc_n;
	logic [7:0]               crc_lo_q, crc_lo_n;
	logic                     crc_idx_q, crc_idx_n;
	logic [COUNTER_WIDTH-1:0] cnt_q [5];
	logic [4:0]               bump;
	mfr_pkg::evt_code_t       ev_n, ev_q;
	logic [7:0]               dout_n, dout_q;
	logic                     out_valid_q;
	logic [7:0]               b;
	logic [15:0]              hdr_len;

	assign b       = head.item.data;
	assign hdr_len = {hfield_q[3], hfield_q[4]};
	assign pop     = head.valid && (!out_valid_q || !out_stall);

	always_comb begin
		phase_n   = phase_q;
		hcount_n  = hcount_q;
		hcrc_n    = hcrc_q;
		hfield_we = 1'b0;
		dcount_n  = dcount_q;
		dcrc_n    = dcrc_q;
		crc_lo_n  = crc_lo_q;
		crc_idx_n = crc_idx_q;
		bump      = 5'b00000;
		ev_n      = mfr_pkg::EV_NONE;
		dout_n    = 8'h00;
		case (phase_q)
			PH_IDLE: begin
				if (head.item.is_sync) begin
					phase_n = PH_PREAMBLE;
				end
			end
			PH_PREAMBLE: begin
				if (head.item.is_flag) begin
					phase_n  = PH_HEADER;
					hcount_n = 3'd0;
					hcrc_n   = mfr_pkg::CRC8_INIT;
				end else if (!head.item.is_sync) begin
					phase_n = PH_IDLE;
				end
			end
			PH_HEADER: begin
				if (hcount_q < 3'(mfr_pkg::HDR_BYTES)) begin
					hfield_we = 1'b1;
					hcrc_n    = mfr_pkg::crc8_update(hcrc_q, b);
					hcount_n  = hcount_q + 3'd1;
				end else begin
					hcount_n = 3'd0;
					phase_n  = PH_IDLE;
					if (~hcrc_q == b) begin
						bump[CNT_FRAMES] = 1'b1;
						bump[CNT_TOKENS] = (hfield_q[0] == 8'h00);
						if (hdr_len != 16'd0 && hdr_len <= max_len_q) begin
							phase_n  = PH_DATA;
							dcount_n = 16'd0;
							dcrc_n   = mfr_pkg::CRC16_INIT;
							ev_n     = mfr_pkg::EV_HDR_DATA;
						end else begin
							ev_n = mfr_pkg::EV_HDR_NODATA;
						end
					end else begin
						bump[CNT_HDR_ERR] = 1'b1;
						ev_n              = mfr_pkg::EV_HDR_CRCERR;
					end
				end
			end
			PH_DATA: begin
				ev_n     = mfr_pkg::EV_DATA;
				dout_n   = b;
				dcrc_n   = mfr_pkg::crc16_update(dcrc_q, b);
				dcount_n = dcount_q + 16'd1;
				if (dcount_n == hdr_len) begin
					phase_n   = PH_CRC16;
					crc_idx_n = 1'b0;
				end
			end
			default: begin
				if (!crc_idx_q) begin
					crc_lo_n  = b;
					crc_idx_n = 1'b1;
				end else begin
					if (~dcrc_q == {b, crc_lo_q}) begin
						bump[CNT_DATA] = 1'b1;
						ev_n           = mfr_pkg::EV_FRAME_OK;
					end else begin
						bump[CNT_DATA_ERR] = 1'b1;
						ev_n               = mfr_pkg::EV_DATA_CRCERR;
					end
					crc_idx_n = 1'b0;
					phase_n   = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= mfr_pkg::MAX_LEN_RESET;
			phase_q     <= PH_IDLE;
			hcount_q    <= 3'd0;
			hcrc_q      <= mfr_pkg::CRC8_INIT;
			dcount_q    <= 16'd0;
			dcrc_q      <= mfr_pkg::CRC16_INIT;
			crc_lo_q    <= 8'h00;
			crc_idx_q   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < mfr_pkg::HDR_BYTES; i++) begin
				hfield_q[i] <= 8'h00;
			end
			for (int i = 0; i < 5; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				max_len_q <= cfg_data;
			end
			if (pop) begin
				phase_q   <= phase_n;
				hcount_q  <= hcount_n;
				hcrc_q    <= hcrc_n;
				dcount_q  <= dcount_n;
				dcrc_q    <= dcrc_n;
				crc_lo_q  <= crc_lo_n;
				crc_idx_q <= crc_idx_n;
				if (hfield_we) begin
					hfield_q[hcount_q] <= b;
				end
				for (int i = 0; i < 5; i++) begin
					if (bump[i] && cnt_q[i] != CNT_MAX) begin
						cnt_q[i] <= cnt_q[i] + COUNTER_WIDTH'(1);
					end
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q   <= ev_n;
			dout_q <= dout_n;
		end
	end

	// state only moves when a result is loaded, so it mirrors the held result
	assign out_valid           = out_valid_q;
	assign event_code          = ev_q;
	assign data_byte_out       = dout_q;
	assign frame_kind          = hfield_q[0];
	assign dest_station        = hfield_q[1];
	assign src_station         = hfield_q[2];
	assign frame_data_length   = hdr_len;
	assign count_frames        = mfr_pkg::CNT_OUT_W'(cnt_q[CNT_FRAMES]);
	assign count_tokens        = mfr_pkg::CNT_OUT_W'(cnt_q[CNT_TOKENS]);
	assign count_data_frames   = mfr_pkg::CNT_OUT_W'(cnt_q[CNT_DATA]);
	assign count_header_errors = mfr_pkg::CNT_OUT_W'(cnt_q[CNT_HDR_ERR]);
	assign count_data_errors   = mfr_pkg::CNT_OUT_W'(cnt_q[CNT_DATA_ERR]);

endmodule

// File: rtl/mstp_frame_receiver_core.sv
// top level of the ms/tp frame receiver
//
// input channel: one received byte per request on rx_byte_in, taken when
//   in_valid is high and in_stall is low
// output channel: exactly one result per byte (event, data byte, current
//   header fields, five saturating counters), taken when out_valid is high
//   and out_stall is low
// config channel: cfg_data writes max_data_length when cfg_valid is high;
//   cfg_ready is always high, write only while the block is idle
// path: a byte is written into the front queue, then popped into the back end
//   and its result loaded into the result register
// throughput: one byte per cycle while the receiver does not stall; the crc
//   update and frame state machine in the back end are combinational
// reset: phase idle, header fields and counters cleared, limit 2000,
//   both channels empty
// receiver stall: the result register holds, the back end stops popping,
//   the two-entry queue fills and in_stall rises once it is full
module mstp_frame_receiver_core #(
	parameter int COUNTER_WIDTH = mfr_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte_in,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [15:0]                   cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    event_code,
	output logic [7:0]                    data_byte_out,
	output logic [7:0]                    frame_kind,
	output logic [7:0]                    dest_station,
	output logic [7:0]                    src_station,
	output logic [15:0]                   frame_data_length,
	output logic [mfr_pkg::CNT_OUT_W-1:0] count_frames,
	output logic [mfr_pkg::CNT_OUT_W-1:0] count_tokens,
	output logic [mfr_pkg::CNT_OUT_W-1:0] count_data_frames,
	output logic [mfr_pkg::CNT_OUT_W-1:0] count_header_errors,
	output logic [mfr_pkg::CNT_OUT_W-1:0] count_data_errors
);

	mfr_pkg::q_head_t head;
	logic             pop;

	// the limit register has no side effects, so a write is always taken
	assign cfg_ready = 1'b1;

	// front: classify each byte against the preamble and queue it
	mfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte_in (rx_byte_in),
		.head       (head),
		.pop        (pop)
	);

	// back: frame sequencing, crc checks, counters and the result register
	mfr_back #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.head                (head),
		.pop                 (pop),
		.cfg_valid           (cfg_valid && cfg_ready),
		.cfg_data            (cfg_data),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.event_code          (event_code),
		.data_byte_out       (data_byte_out),
		.frame_kind          (frame_kind),
		.dest_station        (dest_station),
		.src_station         (src_station),
		.frame_data_length   (frame_data_length),
		.count_frames        (count_frames),
		.count_tokens        (count_tokens),
		.count_data_frames   (count_data_frames),
		.count_header_errors (count_header_errors),
		.count_data_errors   (count_data_errors)
	);

endmodule

// File: rtl/mfr_checker.sv
// port-level checks of the ms/tp frame receiver, bound to the top level
module mfr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [2:0]                    event_code,
	input logic [7:0]                    data_byte_out,
	input logic [mfr_pkg::CNT_OUT_W-1:0] count_frames,
	input logic [mfr_pkg::CNT_OUT_W-1:0] count_tokens
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code)
			&& $stable(data_byte_out))
		else $error("stalled result changed");

	// data byte is zero unless the event is a data byte
	a_dout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_code != mfr_pkg::EV_DATA) |-> data_byte_out == 8'h00)
		else $error("data byte set outside a data event");

	// good header count never goes back
	a_frames_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_frames >= $past(count_frames))
		else $error("frame counter decreased");

	// tokens are a subset of good headers
	a_tokens_le: assert property (@(posedge clk) disable iff (!arst_n)
		count_tokens <= count_frames)
		else $error("token count above frame count");

endmodule

bind mstp_frame_receiver_core mfr_checker u_mfr_checker (.*);

// File: test/tb_top.sv
// self-checking regression bench for the ms/tp frame receiver core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// counter width handed to the core and used by the local model
	localparam int          CNT_W   = mfr_pkg::COUNTER_WIDTH_DEF;
	localparam logic [31:0] CNT_TOP = 32'(((64'd1) << CNT_W) - 64'd1);

	// slots of the five frame counters
	localparam int C_FRAMES   = 0;
	localparam int C_TOKENS   = 1;
	localparam int C_DATA     = 2;
	localparam int C_HDR_ERR  = 3;
	localparam int C_DATA_ERR = 4;

	// bytes per random phase
	localparam int PHASE_BYTES = 175;

	typedef enum logic [2:0] {
		RX_IDLE,
		RX_SYNC,
		RX_HEADER,
		RX_DATA,
		RX_CRC
	} rx_phase_e;

	// everything one received byte should produce on the result channel
	typedef struct packed {
		mfr_pkg::evt_code_t ev;
		logic [7:0]         dbyte;
		logic [7:0]         kind;
		logic [7:0]         dest;
		logic [7:0]         src;
		logic [15:0]        len;
		logic [4:0][31:0]   cnt;
	} rx_result_t;

	// how a directed row gets its byte: as written, or as a crc from the model
	// state xor the written value (zero gives a good crc)
	typedef enum logic [1:0] {
		FILL_NONE,
		FILL_HDR_CRC,
		FILL_CRC_LO,
		FILL_CRC_HI
	} fill_e;

	typedef struct packed {
		fill_e              fill;
		logic [7:0]         val;
		logic               typed;
		mfr_pkg::evt_code_t ev;
	} byte_row_t;

	// directed opening: stray byte, broken preamble, repeated sync, a token
	// frame with one data byte and good crc, then a header of ones but for a zero destination, with a bad crc
	localparam byte_row_t OPENING_ROWS [0:22] = '{
		'{FILL_NONE,    8'h00, 1'b1, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'h55, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'h12, 1'b1, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'h55, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'h55, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'hFF, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'h00, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'hFF, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'h00, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'h00, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'h01, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_HDR_CRC, 8'h00, 1'b1, mfr_pkg::EV_HDR_DATA},
		'{FILL_NONE,    8'hFF, 1'b1, mfr_pkg::EV_DATA},
		'{FILL_CRC_LO,  8'h00, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_CRC_HI,  8'h00, 1'b1, mfr_pkg::EV_FRAME_OK},
		'{FILL_NONE,    8'h55, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'hFF, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'hFF, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'h00, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'hFF, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'hFF, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_NONE,    8'hFF, 1'b0, mfr_pkg::EV_NONE},
		'{FILL_HDR_CRC, 8'hFF, 1'b1, mfr_pkg::EV_HDR_CRCERR}
	};

	// block ports, every input driven to a known value from time zero
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte_in = 8'h00;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = 16'h0000;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_code;
	logic [7:0]  data_byte_out;
	logic [7:0]  frame_kind;
	logic [7:0]  dest_station;
	logic [7:0]  src_station;
	logic [15:0] frame_data_length;
	logic [mfr_pkg::CNT_OUT_W-1:0] count_frames;
	logic [mfr_pkg::CNT_OUT_W-1:0] count_tokens;
	logic [mfr_pkg::CNT_OUT_W-1:0] count_data_frames;
	logic [mfr_pkg::CNT_OUT_W-1:0] count_header_errors;
	logic [mfr_pkg::CNT_OUT_W-1:0] count_data_errors;

	// local copy of the receiver state, advanced once per accepted byte
	rx_phase_e   p_phase   = RX_IDLE;
	logic [2:0]  p_hcnt    = 3'd0;
	logic [7:0]  p_hcrc    = mfr_pkg::CRC8_INIT;
	logic [7:0]  p_hdr [5] = '{default: 8'h00};
	logic [15:0] p_dcnt    = 16'h0000;
	logic [15:0] p_dcrc    = mfr_pkg::CRC16_INIT;
	logic [7:0]  p_crc_lo  = 8'h00;
	logic        p_crc_sel = 1'b0;
	logic [31:0] p_cnt [5] = '{default: 32'h0};
	logic [15:0] rx_limit  = mfr_pkg::MAX_LEN_RESET;

	// results still owed by the block, oldest first
	rx_result_t pending_results [$];

	int mismatches   = 0;
	int bytes_taken  = 0;
	int sender_odds  = 0;
	int receiver_odds = 0;
	int stall_left   = 0;

	mstp_frame_receiver_core #(
		.COUNTER_WIDTH(CNT_W)
	) DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.rx_byte_in         (rx_byte_in),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.event_code         (event_code),
		.data_byte_out      (data_byte_out),
		.frame_kind         (frame_kind),
		.dest_station       (dest_station),
		.src_station        (src_station),
		.frame_data_length  (frame_data_length),
		.count_frames       (count_frames),
		.count_tokens       (count_tokens),
		.count_data_frames  (count_data_frames),
		.count_header_errors(count_header_errors),
		.count_data_errors  (count_data_errors)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// serial crcs worked bit by bit, lsb of the byte first
	function automatic logic [7:0] hdr_crc_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb)
				c = c ^ mfr_pkg::CRC8_POLY;
		end
		return c;
	endfunction

	function automatic logic [15:0] data_crc_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb)
				c = c ^ mfr_pkg::CRC16_POLY;
		end
		return c;
	endfunction

	// saturating bump of one frame counter
	function automatic void bump_counter(input int slot);
		if (p_cnt[slot] < CNT_TOP)
			p_cnt[slot] = p_cnt[slot] + 32'd1;
	endfunction

	// advance the receiver model by one byte and return the result it owes
	function automatic rx_result_t receive_byte(input logic [7:0] b);
		rx_result_t r;
		logic [15:0] len;
		r   = '0;
		len = {p_hdr[3], p_hdr[4]};
		case (p_phase)
			RX_IDLE: begin
				if (b == mfr_pkg::SYNC_BYTE)
					p_phase = RX_SYNC;
			end
			RX_SYNC: begin
				if (b == mfr_pkg::FLAG_BYTE) begin
					p_phase = RX_HEADER;
					p_hcnt  = 3'd0;
					p_hcrc  = mfr_pkg::CRC8_INIT;
				end else if (b != mfr_pkg::SYNC_BYTE) begin
					p_phase = RX_IDLE;
				end
			end
			RX_HEADER: begin
				if (p_hcnt < 3'd5) begin
					p_hdr[p_hcnt] = b;
					p_hcrc        = hdr_crc_next(p_hcrc, b);
					p_hcnt        = p_hcnt + 3'd1;
				end else begin
					p_hcnt = 3'd0;
					if (8'(~p_hcrc) == b) begin
						bump_counter(C_FRAMES);
						if (p_hdr[0] == 8'h00)
							bump_counter(C_TOKENS);
						// zero length or over the limit: header only
						if (len != 16'h0000 && len <= rx_limit) begin
							p_phase = RX_DATA;
							p_dcnt  = 16'h0000;
							p_dcrc  = mfr_pkg::CRC16_INIT;
							r.ev    = mfr_pkg::EV_HDR_DATA;
						end else begin
							p_phase = RX_IDLE;
							r.ev    = mfr_pkg::EV_HDR_NODATA;
						end
					end else begin
						bump_counter(C_HDR_ERR);
						p_phase = RX_IDLE;
						r.ev    = mfr_pkg::EV_HDR_CRCERR;
					end
				end
			end
			RX_DATA: begin
				r.ev    = mfr_pkg::EV_DATA;
				r.dbyte = b;
				p_dcrc  = data_crc_next(p_dcrc, b);
				p_dcnt  = p_dcnt + 16'd1;
				if (p_dcnt == len) begin
					p_phase   = RX_CRC;
					p_crc_sel = 1'b0;
				end
			end
			default: begin
				// crc-16 arrives low byte first
				if (!p_crc_sel) begin
					p_crc_lo  = b;
					p_crc_sel = 1'b1;
				end else begin
					if (16'(~p_dcrc) == {b, p_crc_lo}) begin
						bump_counter(C_DATA);
						r.ev = mfr_pkg::EV_FRAME_OK;
					end else begin
						bump_counter(C_DATA_ERR);
						r.ev = mfr_pkg::EV_DATA_CRCERR;
					end
					p_crc_sel = 1'b0;
					p_phase   = RX_IDLE;
				end
			end
		endcase
		r.kind = p_hdr[0];
		r.dest = p_hdr[1];
		r.src  = p_hdr[2];
		r.len  = {p_hdr[3], p_hdr[4]};
		for (int k = 0; k < 5; k++)
			r.cnt[k] = p_cnt[k];
		return r;
	endfunction

	// one line per mismatch
	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		mismatches++;
		$display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// present one byte, hold it until the request is taken, then predict
	task automatic send_byte(input logic [7:0] b, input logic typed,
			input mfr_pkg::evt_code_t tev);
		int         gap;
		rx_result_t want;
		if (sender_odds != 0 && $urandom_range(0, sender_odds - 1) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		rx_byte_in <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// a byte the block just drops while idle is not counted as stimulus
		if (!(p_phase == RX_IDLE && b != mfr_pkg::SYNC_BYTE))
			bytes_taken++;
		want = receive_byte(b);
		if (typed)
			want.ev = tev;
		pending_results.push_back(want);
	endtask

	// stop sending and wait until every owed result has been taken
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// leave a little margin after the last result
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		rx_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one random burst: mostly well-formed frames, some noise and broken preambles
	task automatic send_frame();
		int          pick;
		logic [7:0]  b;
		logic [7:0]  flip8;
		logic [15:0] flip;
		logic [15:0] len;
		// bring the receiver back to idle first; a pending header is closed with a bad crc
		while (p_phase != RX_IDLE) begin
			case (p_phase)
				RX_SYNC:   b = 8'h00;
				RX_HEADER: b = (p_hcnt == 3'd5) ? 8'(~p_hcrc ^ 8'h01) : 8'($urandom);
				default:   b = 8'($urandom);
			endcase
			send_byte(b, 1'b0, mfr_pkg::EV_NONE);
		end
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			// line noise, now and then a sync byte
			repeat ($urandom_range(1, 6)) begin
				b = ($urandom_range(0, 3) == 0) ? mfr_pkg::SYNC_BYTE : 8'($urandom);
				send_byte(b, 1'b0, mfr_pkg::EV_NONE);
			end
		end else if (pick < 18) begin
			// preamble broken by a byte that is neither sync nor flag
			repeat ($urandom_range(1, 2))
				send_byte(mfr_pkg::SYNC_BYTE, 1'b0, mfr_pkg::EV_NONE);
			b = 8'($urandom);
			if (b == mfr_pkg::SYNC_BYTE || b == mfr_pkg::FLAG_BYTE)
				b = 8'h00;
			send_byte(b, 1'b0, mfr_pkg::EV_NONE);
		end else begin
			repeat ($urandom_range(1, 3))
				send_byte(mfr_pkg::SYNC_BYTE, 1'b0, mfr_pkg::EV_NONE);
			send_byte(mfr_pkg::FLAG_BYTE, 1'b0, mfr_pkg::EV_NONE);
			case ($urandom_range(0, 9))
				0: len = 16'h0000;
				1: begin
					// just over the limit, or the largest length; a small length if the limit is at its top
					if (rx_limit == 16'hFFFF)
						len = 16'($urandom_range(1, 24));
					else
						len = $urandom_range(0, 1) ? rx_limit + 16'd1 : 16'hFFFF;
				end
				2: begin
					if (rx_limit != 16'h0000 && rx_limit <= 16'd40)
						len = rx_limit;
					else
						len = 16'($urandom_range(1, 24));
				end
				default: len = 16'($urandom_range(1, 24));
			endcase
			// frame type zero is a token
			b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
			send_byte(b, 1'b0, mfr_pkg::EV_NONE);
			send_byte(8'($urandom), 1'b0, mfr_pkg::EV_NONE);
			send_byte(8'($urandom), 1'b0, mfr_pkg::EV_NONE);
			send_byte(len[15:8], 1'b0, mfr_pkg::EV_NONE);
			send_byte(len[7:0], 1'b0, mfr_pkg::EV_NONE);
			flip8 = ($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255));
			send_byte(8'(~p_hcrc ^ flip8), 1'b0, mfr_pkg::EV_NONE);
			while (p_phase == RX_DATA) begin
				case ($urandom_range(0, 7))
					0:       b = mfr_pkg::SYNC_BYTE;
					1:       b = mfr_pkg::FLAG_BYTE;
					default: b = 8'($urandom);
				endcase
				send_byte(b, 1'b0, mfr_pkg::EV_NONE);
			end
			if (p_phase == RX_CRC) begin
				flip = ($urandom_range(0, 99) < 85) ? 16'h0000 : 16'($urandom_range(1, 65535));
				send_byte(8'(~p_dcrc[7:0] ^ flip[7:0]), 1'b0, mfr_pkg::EV_NONE);
				send_byte(8'(~p_dcrc[15:8] ^ flip[15:8]), 1'b0, mfr_pkg::EV_NONE);
			end
		end
	endtask

	// receiver back-pressure in random bursts
	always @(negedge clk) begin
		if (receiver_odds != 0 && stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (receiver_odds != 0 && $urandom_range(0, receiver_odds - 1) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(1, 14) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker: every taken result against the oldest owed one
	always @(posedge clk) begin
		rx_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing owed, event", 64'(event_code), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (event_code !== want.ev)
					report_mismatch("event_code", 64'(event_code), 64'(want.ev));
				if (data_byte_out !== want.dbyte)
					report_mismatch("data_byte_out", 64'(data_byte_out), 64'(want.dbyte));
				if (frame_kind !== want.kind)
					report_mismatch("frame_kind", 64'(frame_kind), 64'(want.kind));
				if (dest_station !== want.dest)
					report_mismatch("dest_station", 64'(dest_station), 64'(want.dest));
				if (src_station !== want.src)
					report_mismatch("src_station", 64'(src_station), 64'(want.src));
				if (frame_data_length !== want.len)
					report_mismatch("frame_data_length", 64'(frame_data_length),
							64'(want.len));
				if (count_frames !== want.cnt[C_FRAMES])
					report_mismatch("count_frames", 64'(count_frames),
							64'(want.cnt[C_FRAMES]));
				if (count_tokens !== want.cnt[C_TOKENS])
					report_mismatch("count_tokens", 64'(count_tokens),
							64'(want.cnt[C_TOKENS]));
				if (count_data_frames !== want.cnt[C_DATA])
					report_mismatch("count_data_frames", 64'(count_data_frames),
							64'(want.cnt[C_DATA]));
				if (count_header_errors !== want.cnt[C_HDR_ERR])
					report_mismatch("count_header_errors", 64'(count_header_errors),
							64'(want.cnt[C_HDR_ERR]));
				if (count_data_errors !== want.cnt[C_DATA_ERR])
					report_mismatch("count_data_errors", 64'(count_data_errors),
							64'(want.cnt[C_DATA_ERR]));
			end
		end
	end

	// main sequence
	initial begin
		byte_row_t   row;
		logic [7:0]  b;
		logic [15:0] lim;
		int          target;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed opening at the reset limit, with some sender gaps and receiver stalls
		sender_odds   = 4;
		receiver_odds = 4;
		foreach (OPENING_ROWS[i]) begin
			row = OPENING_ROWS[i];
			case (row.fill)
				FILL_HDR_CRC: b = 8'(~p_hcrc ^ row.val);
				FILL_CRC_LO:  b = 8'(~p_dcrc[7:0] ^ row.val);
				FILL_CRC_HI:  b = 8'(~p_dcrc[15:8] ^ row.val);
				default:      b = row.val;
			endcase
			send_byte(b, row.typed, row.ev);
		end

		// random phases, each at its own limit: smallest, largest, zero (nothing
		// has data), a small random one, forty, and back to the reset value;
		// the last phase runs without any gaps or stalls
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lim = 16'd1;
				1: lim = 16'hFFFF;
				2: lim = 16'd0;
				3: lim = 16'($urandom_range(2, 12));
				4: lim = 16'd40;
				default: lim = mfr_pkg::MAX_LEN_RESET;
			endcase
			drain_results();
			write_limit(lim);
			case (ph)
				0: begin sender_odds = 3;  receiver_odds = 3; end
				1: begin sender_odds = 0;  receiver_odds = 5; end
				2: begin sender_odds = 6;  receiver_odds = 0; end
				3: begin sender_odds = 2;  receiver_odds = 2; end
				4: begin sender_odds = 10; receiver_odds = 4; end
				default: begin sender_odds = 0; receiver_odds = 0; end
			endcase
			target = bytes_taken + PHASE_BYTES;
			while (bytes_taken < target)
				send_frame();
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("mstp_frame_receiver_core regression: pass");
		else
			$display("mstp_frame_receiver_core regression: fail");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("mstp_frame_receiver_core regression: fail");
		$finish;
	end

endmodule
